/* rtl/stst_pkg.sv */
package stst_pkg;

  // Field widths of the beats on both channels
  localparam int FIELD_W   = 16;
  localparam int WIDE_W    = 24;
  localparam int FRAC_BITS = 8;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef struct packed {
    logic                      mode;
    logic signed [FIELD_W-1:0] sample;
  } stst_in_t;

  typedef struct packed {
    status_t                   status;
    logic signed [FIELD_W-1:0] minimum;
    logic signed [FIELD_W-1:0] maximum;
    logic signed [WIDE_W-1:0]  mean_value;
    logic        [WIDE_W-1:0]  deviation;
    logic        [FIELD_W-1:0] sample_count;
  } stst_out_t;

endpackage

/* rtl/stst_accum.sv */
module stst_accum #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    add_en,
  input  logic [stst_pkg::FIELD_W-1:0]            sample_bits,
  output logic signed [SAMPLE_BITS-1:0]           min_val,
  output logic signed [SAMPLE_BITS-1:0]           max_val,
  output logic signed [SAMPLE_BITS+COUNT_BITS-1:0] sum_val,
  output logic [2*SAMPLE_BITS+COUNT_BITS-3:0]     sumsq_val,
  output logic [COUNT_BITS-1:0]                   count_val,
  output logic                                    overflow
);

  localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_W   = 2*SAMPLE_BITS + COUNT_BITS - 2;
  localparam int PROD_W = 2*SAMPLE_BITS - 1;
  localparam int RAW_W  = SAMPLE_BITS + stst_pkg::FIELD_W;

  logic [RAW_W-1:0]                raw_ext;
  logic signed [SAMPLE_BITS-1:0]   smp;
  logic signed [2*SAMPLE_BITS-1:0] prod;
  logic                            full;
  logic                            take;

  logic signed [SAMPLE_BITS-1:0]   min_r;
  logic signed [SAMPLE_BITS-1:0]   max_r;
  logic signed [SUM_W-1:0]         sum_r;
  logic [SQ_W-1:0]                 sumsq_r;
  logic [COUNT_BITS-1:0]           count_r;
  logic                            overflow_r;
  logic [PROD_W-1:0]               sq_r;
  logic                            sq_vld_r;

  // Take the low SAMPLE_BITS of the field as a two's complement value
  assign raw_ext = {SAMPLE_BITS'(0), sample_bits};
  assign smp     = $signed(raw_ext[SAMPLE_BITS-1:0]);
  assign prod    = smp * smp;
  assign full    = &count_r;
  assign take    = add_en && !full;

  // Fold the sample in; the square joins the sum of squares in the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r      <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      max_r      <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      sum_r      <= '0;
      sumsq_r    <= '0;
      count_r    <= '0;
      overflow_r <= 1'b0;
      sq_vld_r   <= 1'b0;
    end else begin
      sq_vld_r <= take;
      if (take) begin
        if (smp < min_r) min_r <= smp;
        if (smp > max_r) max_r <= smp;
        sum_r   <= sum_r + SUM_W'(smp);
        count_r <= count_r + COUNT_BITS'(1);
      end
      if (add_en && full) overflow_r <= 1'b1;
      if (sq_vld_r) sumsq_r <= sumsq_r + SQ_W'(sq_r);
    end
  end

  // Hold the square of the accepted sample
  always_ff @(posedge clk) begin
    if (take) sq_r <= prod[PROD_W-1:0];
  end

  assign min_val   = min_r;
  assign max_val   = max_r;
  assign sum_val   = sum_r;
  assign sumsq_val = sumsq_r;
  assign count_val = count_r;
  assign overflow  = overflow_r;

endmodule

/* rtl/stst_eval.sv */
module stst_eval #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  input  logic [COUNT_BITS-1:0]                    n,
  input  logic signed [SAMPLE_BITS+COUNT_BITS-1:0] sum,
  input  logic [2*SAMPLE_BITS+COUNT_BITS-3:0]      sumsq,
  output logic                                     busy,
  output logic                                     done,
  output logic [stst_pkg::WIDE_W-1:0]              mean_out,
  output logic [stst_pkg::WIDE_W-1:0]              dev_out
);

  localparam int FRAC   = stst_pkg::FRAC_BITS;
  localparam int OUT_W  = stst_pkg::WIDE_W;
  localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
  localparam int MAG_W  = SUM_W - 1;
  localparam int SQ_W   = 2*SAMPLE_BITS + COUNT_BITS - 2;
  localparam int NUM_W  = 2*MAG_W;
  localparam int ACC_W  = NUM_W + 1;
  localparam int LO_W   = 2*FRAC;
  localparam int RAD_W  = NUM_W + LO_W;
  localparam int ROOT_W = RAD_W / 2;
  localparam int DIV_W  = MAG_W + FRAC;
  localparam int SREM_W = ROOT_W + 1;
  localparam int STRY_W = ROOT_W + 3;
  localparam int CNT_W  = $clog2(DIV_W + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIVM = 7'b0000010,
    S_MULN = 7'b0000100,
    S_MULM = 7'b0001000,
    S_SQRT = 7'b0010000,
    S_DIVD = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t               state_r;
  state_t               state_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic                 last;

  logic                 sum_neg;
  logic [SUM_W-1:0]     sum_abs;
  logic [MAG_W-1:0]     mag;
  logic                 neg_r;

  logic [DIV_W-1:0]     dvd_r;
  logic [COUNT_BITS-1:0] rem_r;
  logic [COUNT_BITS:0]  div_try;
  logic                 div_ge;
  logic [COUNT_BITS:0]  div_rem;
  logic [DIV_W-1:0]     dvd_step;
  logic [DIV_W-1:0]     mean_q_r;

  logic [ACC_W-1:0]     acc_r;
  logic [NUM_W-1:0]     mc_r;
  logic [MAG_W-1:0]     mp_r;
  logic [ACC_W-1:0]     acc_plus;
  logic [ACC_W-1:0]     acc_minus;
  logic [ACC_W-1:0]     acc_mm;
  logic [NUM_W-1:0]     num_pos;

  logic [RAD_W-1:0]     rad_r;
  logic [ROOT_W-1:0]    root_r;
  logic [SREM_W-1:0]    srem_r;
  logic [STRY_W-1:0]    sq_try;
  logic [STRY_W-1:0]    sq_trial;
  logic                 sq_ge;
  logic [STRY_W-1:0]    sq_rem;
  logic [ROOT_W-1:0]    root_step;

  logic [DIV_W+OUT_W-1:0] mq_ext;
  logic [DIV_W+OUT_W-1:0] mq_sgn;
  logic [DIV_W+OUT_W-1:0] dq_ext;

  assign last = (cnt_r == CNT_W'(1));

  // Magnitude and sign of the running sum
  assign sum_neg = sum[SUM_W-1];
  assign sum_abs = sum_neg ? (SUM_W'(0) - $unsigned(sum)) : $unsigned(sum);
  assign mag     = sum_abs[MAG_W-1:0];

  // One restoring divide step by the sample count
  assign div_try  = {rem_r, dvd_r[DIV_W-1]};
  assign div_ge   = (div_try >= {1'b0, n});
  assign div_rem  = div_ge ? (div_try - {1'b0, n}) : div_try;
  assign dvd_step = {dvd_r[DIV_W-2:0], div_ge};

  // One shift-add step of n*sumsq - mag*mag
  assign acc_plus  = acc_r + ACC_W'(mc_r);
  assign acc_minus = acc_r - ACC_W'(mc_r);
  assign acc_mm    = mp_r[0] ? acc_minus : acc_r;
  assign num_pos   = acc_mm[NUM_W] ? NUM_W'(0) : acc_mm[NUM_W-1:0];

  // One root bit per step from two radicand bits
  assign sq_try    = {srem_r, rad_r[RAD_W-1 -: 2]};
  assign sq_trial  = {1'b0, root_r, 2'b01};
  assign sq_ge     = (sq_try >= sq_trial);
  assign sq_rem    = sq_ge ? (sq_try - sq_trial) : sq_try;
  assign root_step = {root_r[ROOT_W-2:0], sq_ge};

  // Sequence the phases
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = (n == COUNT_BITS'(0)) ? S_DONE : S_DIVM;
      S_DIVM: if (last) state_nxt = S_MULN;
      S_MULN: if (last) state_nxt = S_MULM;
      S_MULM: if (last) state_nxt = S_SQRT;
      S_SQRT: if (last) state_nxt = S_DIVD;
      S_DIVD: if (last) state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Advance the serial datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          neg_r <= sum_neg;
          dvd_r <= {mag, FRAC'(0)};
          rem_r <= '0;
          cnt_r <= CNT_W'(DIV_W);
        end
      end
      S_DIVM: begin
        dvd_r <= dvd_step;
        rem_r <= div_rem[COUNT_BITS-1:0];
        cnt_r <= cnt_r - CNT_W'(1);
        if (last) begin
          mean_q_r <= dvd_step;
          acc_r    <= '0;
          mc_r     <= NUM_W'(sumsq);
          mp_r     <= MAG_W'(n);
          cnt_r    <= CNT_W'(COUNT_BITS);
        end
      end
      S_MULN: begin
        acc_r <= mp_r[0] ? acc_plus : acc_r;
        mc_r  <= {mc_r[NUM_W-2:0], 1'b0};
        mp_r  <= {1'b0, mp_r[MAG_W-1:1]};
        cnt_r <= cnt_r - CNT_W'(1);
        if (last) begin
          mc_r  <= NUM_W'(mag);
          mp_r  <= mag;
          cnt_r <= CNT_W'(MAG_W);
        end
      end
      S_MULM: begin
        acc_r <= acc_mm;
        mc_r  <= {mc_r[NUM_W-2:0], 1'b0};
        mp_r  <= {1'b0, mp_r[MAG_W-1:1]};
        cnt_r <= cnt_r - CNT_W'(1);
        if (last) begin
          rad_r  <= {num_pos, LO_W'(0)};
          root_r <= '0;
          srem_r <= '0;
          cnt_r  <= CNT_W'(ROOT_W);
        end
      end
      S_SQRT: begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        root_r <= root_step;
        srem_r <= sq_rem[SREM_W-1:0];
        cnt_r  <= cnt_r - CNT_W'(1);
        if (last) begin
          dvd_r <= DIV_W'(root_step);
          rem_r <= '0;
          cnt_r <= CNT_W'(DIV_W);
        end
      end
      S_DIVD: begin
        dvd_r <= dvd_step;
        rem_r <= div_rem[COUNT_BITS-1:0];
        cnt_r <= cnt_r - CNT_W'(1);
      end
      S_DONE: begin
        cnt_r <= cnt_r;
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  // Apply the sign to the mean and trim both to the result width
  assign mq_ext   = {OUT_W'(0), mean_q_r};
  assign mq_sgn   = neg_r ? ((DIV_W+OUT_W)'(0) - mq_ext) : mq_ext;
  assign dq_ext   = {OUT_W'(0), dvd_r};
  assign mean_out = mq_sgn[OUT_W-1:0];
  assign dev_out  = dq_ext[OUT_W-1:0];

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

endmodule

/* rtl/stream_statistics.sv */
// Add beats (mode 0) are taken one per cycle unless an evaluate is running; the square joins
// the sum of squares in the cycle after. An evaluate beat holds the input while the bit-serial
// divider (twice), shift-add multiplier and square root run, then the result sits in the output
// register. With no samples the evaluator skips straight to done and loads the output register.
// Synchronous active-low reset clears min/max to their extremes, sums, count, overflow flag
// and the output valid.
module stream_statistics #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stst_pkg::stst_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stst_pkg::stst_out_t out_data
);

  localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_W  = 2*SAMPLE_BITS + COUNT_BITS - 2;
  localparam int FW    = stst_pkg::FIELD_W;

  logic                          in_take;
  logic                          add_en;
  logic                          eval_start;
  logic signed [SAMPLE_BITS-1:0] min_val;
  logic signed [SAMPLE_BITS-1:0] max_val;
  logic signed [SUM_W-1:0]       sum_val;
  logic [SQ_W-1:0]               sumsq_val;
  logic [COUNT_BITS-1:0]         count_val;
  logic                          overflow;
  logic                          eval_busy;
  logic                          eval_done;
  logic [stst_pkg::WIDE_W-1:0]   mean_w;
  logic [stst_pkg::WIDE_W-1:0]   dev_w;

  logic signed [SAMPLE_BITS+FW-1:0] min_ext;
  logic signed [SAMPLE_BITS+FW-1:0] max_ext;
  logic [COUNT_BITS+FW-1:0]         cnt_ext;
  logic                             empty;
  stst_pkg::stst_out_t              res;

  logic                out_valid_r;
  stst_pkg::stst_out_t out_data_r;

  // Hold input while evaluating, and hold a new evaluate while a result waits
  assign in_stall   = eval_busy || (in_data.mode && out_valid_r);
  assign in_take    = in_valid && !in_stall;
  assign add_en     = in_take && !in_data.mode;
  assign eval_start = in_take && in_data.mode;

  stst_accum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .add_en      (add_en),
    .sample_bits (in_data.sample),
    .min_val     (min_val),
    .max_val     (max_val),
    .sum_val     (sum_val),
    .sumsq_val   (sumsq_val),
    .count_val   (count_val),
    .overflow    (overflow)
  );

  stst_eval #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_eval (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (eval_start),
    .n        (count_val),
    .sum      (sum_val),
    .sumsq    (sumsq_val),
    .busy     (eval_busy),
    .done     (eval_done),
    .mean_out (mean_w),
    .dev_out  (dev_w)
  );

  // Assemble the result beat
  assign min_ext = (SAMPLE_BITS+FW)'(min_val);
  assign max_ext = (SAMPLE_BITS+FW)'(max_val);
  assign cnt_ext = {FW'(0), count_val};
  assign empty   = (count_val == COUNT_BITS'(0));

  always_comb begin
    if (empty) begin
      res.status       = stst_pkg::ST_EMPTY;
      res.minimum      = '0;
      res.maximum      = '0;
      res.mean_value   = '0;
      res.deviation    = '0;
      res.sample_count = '0;
    end else begin
      res.status       = overflow ? stst_pkg::ST_DROPPED : stst_pkg::ST_OK;
      res.minimum      = min_ext[FW-1:0];
      res.maximum      = max_ext[FW-1:0];
      res.mean_value   = mean_w;
      res.deviation    = dev_w;
      res.sample_count = cnt_ext[FW-1:0];
    end
  end

  // Output register: load on done, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eval_done) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_done) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/stst_checker.sv */
module stst_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input stst_pkg::stst_out_t out_data
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Reset drops any pending result
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Empty status carries all-zero statistics
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == stst_pkg::ST_EMPTY |->
      out_data.minimum == '0 && out_data.maximum == '0 && out_data.mean_value == '0 &&
      out_data.deviation == '0 && out_data.sample_count == '0)
    else $error("empty result with nonzero fields");

  // Non-empty result has samples and ordered extremes
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != stst_pkg::ST_EMPTY |->
      out_data.sample_count != '0 && out_data.minimum <= out_data.maximum)
    else $error("non-empty result with bad count or extremes");

  // Mean lies between the extremes
  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != stst_pkg::ST_EMPTY |->
      $signed({out_data.minimum, 8'h00}) <= out_data.mean_value &&
      out_data.mean_value <= $signed({out_data.maximum, 8'h00}))
    else $error("mean outside min/max");

endmodule

bind stream_statistics stst_checker u_stst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_EVAL = 1'b1;
  localparam logic [15:0] COUNT_FULL = 16'hFFFF;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 600;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  stst_pkg::stst_in_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  stst_pkg::stst_out_t out_data;

  // Running statistics as the block should hold them
  logic signed [15:0]  min_seen = 16'sh7FFF;
  logic signed [15:0]  max_seen = 16'sh8000;
  logic [63:0]         sum_acc = '0;
  logic [63:0]         square_acc = '0;
  logic [15:0]         count_acc = '0;
  logic                dropped_flag = 1'b0;
  stst_pkg::stst_out_t pending_summaries[$];

  int          error_count = 0;
  int          summaries_checked = 0;
  int          dropped_adds = 0;
  bit          idle_on = 1'b1;
  int          hold_left = 0;
  int unsigned cycle_count = 0;

  stream_statistics dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fold one accepted sample into the running statistics
  function automatic void fold_sample(logic signed [15:0] value);
    longint sval;
    sval = value;
    if (count_acc == COUNT_FULL) begin
      dropped_flag = 1'b1;
      dropped_adds++;
      return;
    end
    if (value < min_seen) min_seen = value;
    if (value > max_seen) max_seen = value;
    sum_acc = sum_acc + 64'(sval);
    square_acc = square_acc + 64'(sval * sval);
    count_acc++;
  endfunction

  // Work out the summary an evaluate beat should report
  function automatic stst_pkg::stst_out_t summarize_stats();
    stst_pkg::stst_out_t result;
    logic [127:0] n_w, mag_w, num, scaled, root, trial;
    logic [63:0]  mag, quot;
    logic         neg;
    result = '0;
    if (count_acc == '0) begin
      result.status = stst_pkg::ST_EMPTY;
      return result;
    end
    neg = sum_acc[63];
    mag = neg ? -sum_acc : sum_acc;
    quot = (mag << 8) / 64'(count_acc);
    n_w = 128'(count_acc);
    mag_w = 128'(mag);
    num = n_w * 128'(square_acc) - mag_w * mag_w;
    // a negative variance term only follows accumulator wrap
    if (num[127]) num = '0;
    scaled = num << 16;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= scaled) root = trial;
    end
    root = root / n_w;
    result.status = dropped_flag ? stst_pkg::ST_DROPPED : stst_pkg::ST_OK;
    result.minimum = min_seen;
    result.maximum = max_seen;
    result.mean_value = neg ? -quot[23:0] : quot[23:0];
    result.deviation = root[23:0];
    result.sample_count = count_acc;
    return result;
  endfunction

  // Mostly full-range values, with the extremes and values near zero mixed in
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'(int'($urandom_range(0, 6)) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic check_field(input string label, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
    end
  endtask

  // Offer one beat, hold it until accepted, then update the prediction
  task automatic send_beat(input logic mode, input logic signed [15:0] value);
    stst_pkg::stst_in_t beat;
    beat.mode = mode;
    beat.sample = value;
    while (idle_on && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (beat.mode == MODE_EVAL) begin
      pending_summaries.insert(pending_summaries.size(), summarize_stats());
    end else begin
      fold_sample(beat.sample);
    end
  endtask

  // Check each result beat against the oldest summary, then pick the next stall
  always @(posedge clk) begin : rx_check
    stst_pkg::stst_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_summaries.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
      end else begin
        want = pending_summaries.pop_front();
        summaries_checked++;
        check_field("status", want.status, out_data.status);
        check_field("minimum", want.minimum, out_data.minimum);
        check_field("maximum", want.maximum, out_data.maximum);
        check_field("mean_value", want.mean_value, out_data.mean_value);
        check_field("deviation", want.deviation, out_data.deviation);
        check_field("sample_count", want.sample_count, out_data.sample_count);
      end
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < 14);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Evaluate before any sample has arrived
  task automatic test_empty_status();
    send_beat(MODE_EVAL, 16'sh0000);
    send_beat(MODE_EVAL, 16'($urandom));
  endtask

  // Extreme samples, a negative mean, and evaluates right behind adds
  task automatic test_extremes();
    send_beat(MODE_ADD, 16'sh7FFF);
    send_beat(MODE_EVAL, 16'sh8000);
    send_beat(MODE_ADD, 16'sh8000);
    send_beat(MODE_EVAL, 16'sh7FFF);
    send_beat(MODE_ADD, 16'sh0000);
    send_beat(MODE_ADD, -16'sd1);
    send_beat(MODE_ADD, 16'sd1);
    send_beat(MODE_EVAL, 16'sh0000);
    for (int i = 0; i < 4; i++) begin
      send_beat(MODE_ADD, 16'sh8000);
    end
    send_beat(MODE_EVAL, 16'shFFFF);
    idle_on = 1'b0;
    send_beat(MODE_ADD, -16'sd3);
    send_beat(MODE_EVAL, 16'sh5A5A);
    send_beat(MODE_EVAL, 16'shA5A5);
    idle_on = 1'b1;
  endtask

  // Random adds and evaluates, with a stretch of back-to-back traffic
  task automatic test_random_mix(input int items);
    for (int i = 0; i < items; i++) begin
      idle_on = (i < items / 3) || (i >= items / 2);
      if ($urandom_range(0, 7) == 0) begin
        send_beat(MODE_EVAL, 16'($urandom));
      end else begin
        send_beat(MODE_ADD, pick_sample());
      end
    end
    idle_on = 1'b1;
  endtask

  // Hold off the result side long enough for the input to back up
  task automatic test_output_hold();
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) begin
      if (i % 6 == 5) begin
        send_beat(MODE_EVAL, 16'($urandom));
      end else begin
        send_beat(MODE_ADD, pick_sample());
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_status();
    test_extremes();
    test_random_mix(900);
    test_output_hold();
    // release the input and wait out the remaining results
    in_valid <= 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Folded %0d samples, dropped %0d adds at full count, checked %0d summaries",
             count_acc, dropped_adds, summaries_checked);
    $display("Included empty status, extreme samples, random traffic and a long output hold-off");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/stst_pkg.sv
rtl/stst_accum.sv
rtl/stst_eval.sv
rtl/stream_statistics.sv
rtl/stst_checker.sv
tb/tb.sv
